// ----- hdl/rrhp_pkg.sv -----
// Shared types, constants and field tables of the RPC record header parser.
`timescale 1ns / 1ps
`default_nettype none

package rrhp_pkg;

    localparam int unsigned OPAQUE_MAX = 400;
    localparam logic [9:0]  HLEN_MAX   = 10'd1023;
    localparam logic [30:0] MAX_FRAG_RESET = 31'd1048576;

    // Configuration register indexes
    localparam logic CFG_DIRECTION    = 1'b0;
    localparam logic CFG_MAX_FRAG_LEN = 1'b1;

    // Header word slots
    localparam logic [3:0] SLOT_XID    = 4'd0;
    localparam logic [3:0] SLOT_MTYPE  = 4'd1;
    localparam logic [3:0] SLOT_RPCV   = 4'd2;
    localparam logic [3:0] SLOT_PROG   = 4'd3;
    localparam logic [3:0] SLOT_VERS   = 4'd4;
    localparam logic [3:0] SLOT_PROC   = 4'd5;
    localparam logic [3:0] SLOT_CRED   = 4'd6;
    localparam logic [3:0] SLOT_VERF   = 4'd7;
    localparam logic [3:0] SLOT_RSTAT  = 4'd8;
    localparam logic [3:0] SLOT_ASTAT  = 4'd9;

    localparam logic [3:0] CALL_FIELDS  = 4'd12;
    localparam logic [3:0] REPLY_FIELDS = 4'd7;

    typedef enum logic [2:0] {
        EV_HDR_DONE   = 3'd0,
        EV_MSG_DONE   = 3'd1,
        EV_FRAG_LARGE = 3'd2,
        EV_FRAG_ZERO  = 3'd3,
        EV_WRONG_DIR  = 3'd4,
        EV_INCOMPLETE = 3'd5
    } event_t;

    typedef enum logic {
        PH_MARK = 1'b0,
        PH_BODY = 1'b1
    } phase_t;

    typedef enum logic [1:0] {
        K_WORD = 2'd0,
        K_LEN  = 2'd1,
        K_BODY = 2'd2
    } kind_t;

    // Results caused by one byte: one event, or header done followed by message done
    typedef struct packed {
        event_t      ev0;
        logic        two;
        logic [31:0] xid;
        logic [31:0] rpc_version;
        logic [31:0] program_number;
        logic [31:0] program_version;
        logic [31:0] procedure_number;
        logic [31:0] cred_flavor;
        logic [31:0] verf_flavor;
        logic [31:0] reply_status;
        logic [31:0] accept_status;
        logic [9:0]  hlen;
    } result_group_t;

    function automatic kind_t field_kind(input logic dir, input logic [3:0] pos);
        kind_t k;
        k = K_WORD;
        if (!dir)
        begin
            case (pos)
                4'd7, 4'd10: k = K_LEN;
                4'd8, 4'd11: k = K_BODY;
                default:     k = K_WORD;
            endcase
        end
        else
        begin
            case (pos)
                4'd4:    k = K_LEN;
                4'd5:    k = K_BODY;
                default: k = K_WORD;
            endcase
        end
        return k;
    endfunction

    function automatic logic [3:0] field_slot(input logic dir, input logic [3:0] pos);
        logic [3:0] s;
        s = SLOT_XID;
        if (!dir)
        begin
            case (pos)
                4'd1:    s = SLOT_MTYPE;
                4'd2:    s = SLOT_RPCV;
                4'd3:    s = SLOT_PROG;
                4'd4:    s = SLOT_VERS;
                4'd5:    s = SLOT_PROC;
                4'd6:    s = SLOT_CRED;
                4'd9:    s = SLOT_VERF;
                default: s = SLOT_XID;
            endcase
        end
        else
        begin
            case (pos)
                4'd1:    s = SLOT_MTYPE;
                4'd2:    s = SLOT_RSTAT;
                4'd3:    s = SLOT_VERF;
                4'd6:    s = SLOT_ASTAT;
                default: s = SLOT_XID;
            endcase
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rrhp_byte_if.sv -----
// Stream byte channel and result channel of the RPC record header parser.
`timescale 1ns / 1ps
`default_nettype none

interface rrhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rrhp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [31:0] xid;
    logic [31:0] rpc_version;
    logic [31:0] program_number;
    logic [31:0] program_version;
    logic [31:0] procedure_number;
    logic [31:0] cred_flavor;
    logic [31:0] verf_flavor;
    logic [31:0] reply_status;
    logic [31:0] accept_status;
    logic [9:0]  header_length;
    logic        last_of_run;

    modport source (output valid, output event_res, output xid, output rpc_version,
                    output program_number, output program_version,
                    output procedure_number, output cred_flavor, output verf_flavor,
                    output reply_status, output accept_status, output header_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input event_res, input xid, input rpc_version,
                    input program_number, input program_version,
                    input procedure_number, input cred_flavor, input verf_flavor,
                    input reply_status, input accept_status, input header_length,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hdl/rrhp_parse.sv -----
// Record marker tracker and header field walker, one byte per cycle while results can load.
`timescale 1ns / 1ps
`default_nettype none

module rrhp_parse import rrhp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          direction,
    input  wire logic [30:0]   max_frag_len,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    data_byte,
    input  wire logic          can_load,
    output logic               advance,
    output logic               load,
    output result_group_t      group
);

    phase_t            phase_reg, phase_next;
    logic [1:0]        mcnt_reg, mcnt_next;
    logic [31:0]       mshift_reg, mshift_next;
    logic              last_reg, last_next;
    logic [30:0]       frem_reg, frem_next;
    logic [3:0]        fpos_reg, fpos_next;
    logic [1:0]        fcnt_reg, fcnt_next;
    logic [31:0]       fshift_reg, fshift_next;
    logic [8:0]        orem_reg, orem_next;
    logic              hc_reg, hc_next;
    logic [9:0][31:0]  words_reg, words_next;
    logic [9:0]        hbc_reg, hbc_next;

    // Values before a message clear is applied
    phase_t            phase_w;
    logic [1:0]        mcnt_w;
    logic [31:0]       mshift_w;
    logic              last_w;
    logic [30:0]       frem_w;
    logic [3:0]        fpos_w;
    logic [1:0]        fcnt_w;
    logic [31:0]       fshift_w;
    logic [8:0]        orem_w;
    logic              hc_w;
    logic [9:0][31:0]  words_w;
    logic [9:0]        hbc_w;

    logic              fail;
    event_t            fail_code;
    logic              hdr_done;
    logic              msg_done;
    logic              clear_msg;
    logic              has_result;

    logic [3:0]        nfields;
    kind_t             kind;
    logic [3:0]        slot;
    logic [4:0]        pos;
    logic [30:0]       size;
    logic [31:0]       word;
    logic [32:0]       rounded;
    logic [8:0]        opaque_len;

    assign nfields = direction ? REPLY_FIELDS : CALL_FIELDS;
    assign kind    = field_kind(direction, fpos_reg);
    assign slot    = field_slot(direction, fpos_reg);
    assign size    = mshift_w[30:0];
    assign word    = fshift_w;
    assign rounded = ({1'b0, word} + 33'd3) & ~33'd3;
    assign opaque_len = (rounded > 33'(OPAQUE_MAX)) ? 9'(OPAQUE_MAX) : rounded[8:0];

    always_comb
    begin
        phase_w   = phase_reg;
        mcnt_w    = mcnt_reg;
        mshift_w  = mshift_reg;
        last_w    = last_reg;
        frem_w    = frem_reg;
        fpos_w    = fpos_reg;
        fcnt_w    = fcnt_reg;
        fshift_w  = fshift_reg;
        orem_w    = orem_reg;
        hc_w      = hc_reg;
        words_w   = words_reg;
        fail      = 1'b0;
        fail_code = EV_INCOMPLETE;
        hdr_done  = 1'b0;
        msg_done  = 1'b0;
        pos       = {1'b0, fpos_reg};

        hbc_w = (!hc_reg && hbc_reg != HLEN_MAX) ? hbc_reg + 10'd1 : hbc_reg;

        if (phase_reg == PH_MARK)
        begin
            mshift_w = {mshift_reg[23:0], data_byte};
            mcnt_w   = mcnt_reg + 2'd1;
            if (mcnt_reg == 2'd3)
            begin
                last_w = mshift_w[31];
                if (size > max_frag_len)
                begin
                    fail      = 1'b1;
                    fail_code = EV_FRAG_LARGE;
                end
                else if (size == 31'd0)
                begin
                    fail      = 1'b1;
                    fail_code = EV_FRAG_ZERO;
                end
                else
                begin
                    frem_w  = size;
                    phase_w = PH_BODY;
                end
            end
        end
        else
        begin
            if (!hc_reg && fpos_reg < nfields)
            begin
                if (kind == K_BODY)
                begin
                    orem_w = (orem_reg != 9'd0) ? orem_reg - 9'd1 : orem_reg;
                    if (orem_w == 9'd0)
                        pos = pos + 5'd1;
                end
                else
                begin
                    fshift_w = {fshift_reg[23:0], data_byte};
                    fcnt_w   = fcnt_reg + 2'd1;
                    if (fcnt_reg == 2'd3)
                    begin
                        if (kind == K_WORD)
                        begin
                            words_w[slot] = word;
                            if (slot == SLOT_MTYPE && word != {31'd0, direction})
                            begin
                                fail      = 1'b1;
                                fail_code = EV_WRONG_DIR;
                            end
                            pos = pos + 5'd1;
                        end
                        else
                        begin
                            orem_w = opaque_len;
                            // skip the body step of an empty opaque
                            pos = (opaque_len == 9'd0) ? pos + 5'd2 : pos + 5'd1;
                        end
                    end
                end
                fpos_w = pos[3:0];
                if (!fail && pos >= {1'b0, nfields})
                begin
                    hc_w     = 1'b1;
                    hdr_done = 1'b1;
                end
            end

            if (!fail)
            begin
                frem_w = (frem_reg != 31'd0) ? frem_reg - 31'd1 : frem_reg;
                if (frem_w == 31'd0)
                begin
                    if (!hc_w)
                    begin
                        fail      = 1'b1;
                        fail_code = EV_INCOMPLETE;
                    end
                    else if (last_reg)
                    begin
                        msg_done = 1'b1;
                    end
                    else
                    begin
                        // await the marker of the next fragment
                        phase_w  = PH_MARK;
                        mcnt_w   = 2'd0;
                        mshift_w = 32'd0;
                    end
                end
            end
        end
    end

    assign clear_msg  = fail || msg_done;
    assign has_result = fail || hdr_done || msg_done;
    assign advance    = byte_valid && (!has_result || can_load);
    assign load       = advance && has_result;

    always_comb
    begin
        if (clear_msg)
        begin
            phase_next  = PH_MARK;
            mcnt_next   = 2'd0;
            mshift_next = 32'd0;
            last_next   = 1'b0;
            frem_next   = 31'd0;
            fpos_next   = 4'd0;
            fcnt_next   = 2'd0;
            fshift_next = 32'd0;
            orem_next   = 9'd0;
            hc_next     = 1'b0;
            words_next  = '0;
            hbc_next    = 10'd0;
        end
        else
        begin
            phase_next  = phase_w;
            mcnt_next   = mcnt_w;
            mshift_next = mshift_w;
            last_next   = last_w;
            frem_next   = frem_w;
            fpos_next   = fpos_w;
            fcnt_next   = fcnt_w;
            fshift_next = fshift_w;
            orem_next   = orem_w;
            hc_next     = hc_w;
            words_next  = words_w;
            hbc_next    = hbc_w;
        end
    end

    always_comb
    begin
        group = '0;
        if (fail)
        begin
            group.ev0 = fail_code;
        end
        else
        begin
            group.ev0              = hdr_done ? EV_HDR_DONE : EV_MSG_DONE;
            group.two              = hdr_done && msg_done;
            group.xid              = words_w[SLOT_XID];
            group.rpc_version      = words_w[SLOT_RPCV];
            group.program_number   = words_w[SLOT_PROG];
            group.program_version  = words_w[SLOT_VERS];
            group.procedure_number = words_w[SLOT_PROC];
            group.cred_flavor      = words_w[SLOT_CRED];
            group.verf_flavor      = words_w[SLOT_VERF];
            group.reply_status     = words_w[SLOT_RSTAT];
            group.accept_status    = words_w[SLOT_ASTAT];
            group.hlen             = hbc_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MARK;
            mcnt_reg   <= 2'd0;
            mshift_reg <= 32'd0;
            last_reg   <= 1'b0;
            frem_reg   <= 31'd0;
            fpos_reg   <= 4'd0;
            fcnt_reg   <= 2'd0;
            fshift_reg <= 32'd0;
            orem_reg   <= 9'd0;
            hc_reg     <= 1'b0;
            words_reg  <= '0;
            hbc_reg    <= 10'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            mcnt_reg   <= mcnt_next;
            mshift_reg <= mshift_next;
            last_reg   <= last_next;
            frem_reg   <= frem_next;
            fpos_reg   <= fpos_next;
            fcnt_reg   <= fcnt_next;
            fshift_reg <= fshift_next;
            orem_reg   <= orem_next;
            hc_reg     <= hc_next;
            words_reg  <= words_next;
            hbc_reg    <= hbc_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rrhp_out.sv -----
// Result register: holds the results of one byte and sends them one per transfer.
`timescale 1ns / 1ps
`default_nettype none

module rrhp_out import rrhp_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire result_group_t  group,
    output logic                can_load,
    rrhp_result_if.source       result
);

    logic           valid_reg, valid_next;
    logic           second_reg, second_next;
    result_group_t  grp_reg;
    logic           is_last;
    logic           xfer;

    assign is_last  = !grp_reg.two || second_reg;
    assign xfer     = valid_reg && result.ready;
    assign can_load = !valid_reg || (result.ready && is_last);

    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        if (load)
        begin
            valid_next  = 1'b1;
            second_next = 1'b0;
        end
        else if (xfer)
        begin
            // advance to message done, or drop the finished group
            if (is_last)
                valid_next = 1'b0;
            else
                second_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            grp_reg <= group;
    end

    assign result.valid            = valid_reg;
    assign result.event_res        = second_reg ? EV_MSG_DONE : grp_reg.ev0;
    assign result.xid              = grp_reg.xid;
    assign result.rpc_version      = grp_reg.rpc_version;
    assign result.program_number   = grp_reg.program_number;
    assign result.program_version  = grp_reg.program_version;
    assign result.procedure_number = grp_reg.procedure_number;
    assign result.cred_flavor      = grp_reg.cred_flavor;
    assign result.verf_flavor      = grp_reg.verf_flavor;
    assign result.reply_status     = grp_reg.reply_status;
    assign result.accept_status    = grp_reg.accept_status;
    assign result.header_length    = grp_reg.hlen;
    assign result.last_of_run      = is_last;

endmodule

`default_nettype wire

// ----- hdl/rpc_record_header_parser_core.sv -----
// Top level of the ONC RPC record marking header parser.
`timescale 1ns / 1ps
`default_nettype none

// Parses an ONC RPC over TCP byte stream, one byte per transfer on stream.
// A byte is taken into an input register, then advances the record marker
// tracker and the header field walker and, if it causes any, loads its
// results into the result register. Sustained rate is one byte per cycle
// while results are taken; a byte that ends both the header and the message
// gives two results and holds the next result-causing byte until its second
// result is taken, since the result register sends one result per transfer.
// Errors report zero header fields and return the parser to awaiting a
// message marker. Write direction and max_frag_len only while no byte is in
// flight.

module rpc_record_header_parser_core import rrhp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [30:0]  cfg_data,
    rrhp_byte_if.sink         stream,
    rrhp_result_if.source     result
);

    logic           direction_reg;
    logic [30:0]    max_frag_reg;
    logic           byte_valid_reg;
    logic [7:0]     byte_reg;
    logic           advance;
    logic           load;
    logic           can_load;
    result_group_t  group;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            max_frag_reg  <= MAX_FRAG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIRECTION:    direction_reg <= cfg_data[0];
                CFG_MAX_FRAG_LEN: max_frag_reg  <= cfg_data;
                default:          max_frag_reg  <= max_frag_reg;
            endcase
        end
    end

    assign stream.ready = !byte_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (stream.ready)
            byte_valid_reg <= stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
            byte_reg <= stream.data_byte;
    end

    rrhp_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .direction    (direction_reg),
        .max_frag_len (max_frag_reg),
        .byte_valid   (byte_valid_reg),
        .data_byte    (byte_reg),
        .can_load     (can_load),
        .advance      (advance),
        .load         (load),
        .group        (group)
    );

    rrhp_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .group    (group),
        .can_load (can_load),
        .result   (result)
    );

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for the RPC record header parser: framed call/reply streams checked by a scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import rrhp_pkg::*;

    typedef struct {
        event_t      ev;
        bit [31:0]   xid;
        bit [31:0]   rpcv;
        bit [31:0]   prog;
        bit [31:0]   vers;
        bit [31:0]   proc_no;
        bit [31:0]   cred;
        bit [31:0]   verf;
        bit [31:0]   rstat;
        bit [31:0]   astat;
        bit [9:0]    hlen;
        bit          last;
    } rpc_result_t;

    class rpc_header_scoreboard;
        bit          dir;
        bit [30:0]   max_len;
        phase_t      ph;
        int unsigned mk_cnt;
        bit [31:0]   mk_shift;
        bit          last_frag;
        bit [30:0]   frag_left;
        int unsigned fpos;
        int unsigned fcnt;
        bit [31:0]   fshift;
        int unsigned opq_left;
        bit          hdr_done;
        bit [31:0]   words [10];
        bit [9:0]    hcount;
        rpc_result_t expected_q[$];
        int unsigned errors;
        int unsigned produced;
        int unsigned shown;

        function new();
            dir = 1'b0;
            max_len = MAX_FRAG_RESET;
            errors = 0;
            produced = 0;
            shown = 0;
            clear_msg();
        endfunction

        function void set_reg(bit idx, bit [30:0] val);
            if (idx == CFG_DIRECTION)
                dir = val[0];
            else
                max_len = val;
        endfunction

        function void clear_msg();
            ph = PH_MARK;
            mk_cnt = 0;
            mk_shift = '0;
            last_frag = 1'b0;
            frag_left = '0;
            fpos = 0;
            fcnt = 0;
            fshift = '0;
            opq_left = 0;
            hdr_done = 1'b0;
            foreach (words[i])
                words[i] = '0;
            hcount = '0;
        endfunction

        function kind_t kind_at(int unsigned pos);
            if (dir)
                return (pos == 4) ? K_LEN : ((pos == 5) ? K_BODY : K_WORD);
            if (pos == 7 || pos == 10)
                return K_LEN;
            if (pos == 8 || pos == 11)
                return K_BODY;
            return K_WORD;
        endfunction

        function bit [3:0] slot_at(int unsigned pos);
            bit [3:0] s;
            if (!dir)
                s = (pos == 9) ? SLOT_VERF : 4'(pos);
            else
            begin
                case (pos)
                    1:       s = SLOT_MTYPE;
                    2:       s = SLOT_RSTAT;
                    3:       s = SLOT_VERF;
                    6:       s = SLOT_ASTAT;
                    default: s = SLOT_XID;
                endcase
            end
            return s;
        endfunction

        function rpc_result_t capture(event_t ev, bit with_words);
            rpc_result_t res;
            res.ev      = ev;
            res.xid     = with_words ? words[SLOT_XID]   : '0;
            res.rpcv    = with_words ? words[SLOT_RPCV]  : '0;
            res.prog    = with_words ? words[SLOT_PROG]  : '0;
            res.vers    = with_words ? words[SLOT_VERS]  : '0;
            res.proc_no = with_words ? words[SLOT_PROC]  : '0;
            res.cred    = with_words ? words[SLOT_CRED]  : '0;
            res.verf    = with_words ? words[SLOT_VERF]  : '0;
            res.rstat   = with_words ? words[SLOT_RSTAT] : '0;
            res.astat   = with_words ? words[SLOT_ASTAT] : '0;
            res.hlen    = with_words ? hcount : '0;
            res.last    = 1'b0;
            return res;
        endfunction

        function void abort_msg(event_t ev);
            rpc_result_t res;
            clear_msg();
            res = capture(ev, 1'b0);
            res.last = 1'b1;
            expected_q.push_back(res);
            produced++;
        endfunction

        // 0: still walking, 1: header complete, 2: message type mismatch
        function int walk_header(bit [7:0] b);
            int unsigned n_fields;
            int unsigned pos;
            kind_t       k;
            bit [3:0]    s;
            bit [32:0]   rounded;
            bit [31:0]   word;
            n_fields = dir ? REPLY_FIELDS : CALL_FIELDS;
            pos = fpos;
            if (pos >= n_fields)
                return 0;
            k = kind_at(pos);
            if (k == K_BODY)
            begin
                if (opq_left != 0)
                    opq_left--;
                if (opq_left == 0)
                    pos++;
            end
            else
            begin
                fshift = {fshift[23:0], b};
                fcnt++;
                if (fcnt < 4)
                    return 0;
                fcnt = 0;
                word = fshift;
                if (k == K_WORD)
                begin
                    s = slot_at(pos);
                    words[s] = word;
                    if (s == SLOT_MTYPE && word != {31'b0, dir})
                        return 2;
                    pos++;
                end
                else
                begin
                    // round up without wrap, then clamp
                    rounded = ({1'b0, word} + 33'd3) & ~33'd3;
                    if (rounded > OPAQUE_MAX)
                        rounded = OPAQUE_MAX;
                    opq_left = rounded;
                    pos++;
                    if (opq_left == 0)
                        pos++;
                end
            end
            fpos = pos & 15;
            if (pos >= n_fields)
            begin
                hdr_done = 1'b1;
                return 1;
            end
            return 0;
        endfunction

        function void note_byte(bit [7:0] b);
            rpc_result_t run_q[$];
            bit [30:0]   size;
            int          r;
            if (!hdr_done && hcount != HLEN_MAX)
                hcount++;
            if (ph == PH_MARK)
            begin
                mk_shift = {mk_shift[23:0], b};
                mk_cnt++;
                if (mk_cnt < 4)
                    return;
                mk_cnt = 0;
                last_frag = mk_shift[31];
                size = mk_shift[30:0];
                if (size > max_len)
                    abort_msg(EV_FRAG_LARGE);
                else if (size == 0)
                    abort_msg(EV_FRAG_ZERO);
                else
                begin
                    frag_left = size;
                    ph = PH_BODY;
                end
                return;
            end
            if (!hdr_done)
            begin
                r = walk_header(b);
                if (r == 2)
                begin
                    abort_msg(EV_WRONG_DIR);
                    return;
                end
                if (r == 1)
                    run_q.push_back(capture(EV_HDR_DONE, 1'b1));
            end
            if (frag_left != 0)
                frag_left--;
            if (frag_left == 0)
            begin
                if (!hdr_done)
                begin
                    abort_msg(EV_INCOMPLETE);
                    return;
                end
                if (last_frag)
                begin
                    run_q.push_back(capture(EV_MSG_DONE, 1'b1));
                    clear_msg();
                end
                else
                begin
                    // header done, more fragments follow
                    ph = PH_MARK;
                    mk_cnt = 0;
                    mk_shift = '0;
                end
            end
            if (run_q.size() > 0)
                run_q[run_q.size() - 1].last = 1'b1;
            foreach (run_q[i])
                expected_q.push_back(run_q[i]);
            produced += run_q.size();
        endfunction

        function bit field_bad(string name, longint unsigned want, longint unsigned got);
            if (want == got)
                return 1'b0;
            if (shown < 80)
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            shown++;
            return 1'b1;
        endfunction

        function void check_result(rpc_result_t got);
            rpc_result_t want;
            bit          bad;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (shown < 80)
                    $display("%0t: event_res expected none, actual %0d", $time, got.ev);
                shown++;
                return;
            end
            want = expected_q.pop_front();
            bad = 1'b0;
            bad |= field_bad("event_res", want.ev, got.ev);
            bad |= field_bad("xid", want.xid, got.xid);
            bad |= field_bad("rpc_version", want.rpcv, got.rpcv);
            bad |= field_bad("program_number", want.prog, got.prog);
            bad |= field_bad("program_version", want.vers, got.vers);
            bad |= field_bad("procedure_number", want.proc_no, got.proc_no);
            bad |= field_bad("cred_flavor", want.cred, got.cred);
            bad |= field_bad("verf_flavor", want.verf, got.verf);
            bad |= field_bad("reply_status", want.rstat, got.rstat);
            bad |= field_bad("accept_status", want.astat, got.astat);
            bad |= field_bad("header_length", want.hlen, got.hlen);
            bad |= field_bad("last_of_run", want.last, got.last);
            if (bad)
                errors++;
        endfunction

        function int unsigned waiting();
            return expected_q.size();
        endfunction

        function void flag_leftover();
            foreach (expected_q[i])
            begin
                if (shown < 80)
                    $display("%0t: event_res expected %0d, actual none", $time,
                             expected_q[i].ev);
                shown++;
            end
            errors += expected_q.size();
            expected_q.delete();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [30:0] cfg_data;

    rrhp_byte_if   byte_ch ();
    rrhp_result_if res_ch ();

    rpc_record_header_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (byte_ch),
        .result    (res_ch)
    );

    rpc_header_scoreboard sb = new();

    bit [7:0]    pending_q[$];
    bit [7:0]    msg_q[$];
    bit          cur_dir;
    bit [30:0]   cur_max;
    bit          tx_eager;
    bit          sending;
    int unsigned rand_bytes;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

    function automatic bit [31:0] pick_word(int unsigned fill);
        if (fill == 1)
            return '1;
        if (fill == 2)
            return '0;
        return $urandom;
    endfunction

    function automatic void put_word(bit [31:0] w);
        for (int i = 3; i >= 0; i--)
            msg_q.push_back(w[8 * i +: 8]);
    endfunction

    function automatic void push_marker(bit [31:0] w);
        for (int i = 3; i >= 0; i--)
            pending_q.push_back(w[8 * i +: 8]);
    endfunction

    function automatic void put_opaque(bit [31:0] len);
        bit [32:0] body;
        put_word(len);
        body = ({1'b0, len} + 33'd3) & ~33'd3;
        if (body > OPAQUE_MAX)
            body = OPAQUE_MAX;
        repeat (int'(body))
            msg_q.push_back(8'($urandom));
    endfunction

    function automatic bit [31:0] rand_opaque();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 0;
        if (p < 85)
            return $urandom_range(1, 24);
        if (p < 98)
            return $urandom_range(25, OPAQUE_MAX + 8);
        return $urandom_range(0, 1) ? $urandom : $urandom_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    endfunction

    // returns the number of header bytes placed in msg_q
    function automatic int unsigned build_message(bit reply, bit [31:0] mtype,
                                                  bit [31:0] cred_len, bit [31:0] verf_len,
                                                  int unsigned payload, int unsigned fill);
        int unsigned hdr;
        put_word(pick_word(fill));
        put_word(mtype);
        if (!reply)
        begin
            repeat (5)
                put_word(pick_word(fill));
            put_opaque(cred_len);
            put_word(pick_word(fill));
            put_opaque(verf_len);
        end
        else
        begin
            put_word(pick_word(fill));
            put_word(pick_word(fill));
            put_opaque(verf_len);
            put_word(pick_word(fill));
        end
        hdr = msg_q.size();
        repeat (payload)
            msg_q.push_back(8'($urandom));
        return hdr;
    endfunction

    // split the first keep bytes of msg_q into marked fragments
    function automatic void frame_message(int unsigned keep, int unsigned cap);
        int unsigned left;
        int unsigned sz;
        left = keep;
        while (left > 0)
        begin
            sz = $urandom_range(1, cap);
            if (sz > left)
                sz = left;
            left -= sz;
            push_marker({left == 0, 31'(sz)});
            repeat (sz)
                pending_q.push_back(msg_q.pop_front());
        end
        msg_q.delete();
    endfunction

    function automatic void frame_whole();
        frame_message(msg_q.size(), msg_q.size());
    endfunction

    function automatic void add_random_message();
        int unsigned p;
        int unsigned cap;
        int unsigned hdr;
        int unsigned keep;
        int unsigned fill;
        bit          as_reply;
        bit [31:0]   mtype;
        p = $urandom_range(0, 99);
        cap = $urandom_range(0, 1) ? 32'h4000_0000 : $urandom_range(1, 16);
        if (cap > cur_max)
            cap = cur_max;
        if (p < 4)
        begin
            repeat ($urandom_range(1, 3) * 4)
                pending_q.push_back(8'($urandom));
            return;
        end
        if (p < 9)
        begin
            push_marker({1'($urandom_range(0, 1)), 31'b0});
            return;
        end
        if (p < 14 && cur_max != 31'h7FFF_FFFF)
        begin
            push_marker({1'($urandom_range(0, 1)),
                         31'($urandom_range(32'(cur_max) + 1, 32'h7FFF_FFFF))});
            return;
        end
        as_reply = cur_dir;
        mtype = {31'b0, cur_dir};
        if (p >= 14 && p < 22)
        begin
            as_reply = $urandom_range(0, 1);
            mtype = $urandom_range(0, 1) ? {31'b0, !cur_dir} : $urandom;
        end
        fill = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
        hdr = build_message(as_reply, mtype, rand_opaque(), rand_opaque(),
                            ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24), fill);
        keep = msg_q.size();
        if (p >= 22 && p < 30)
            keep = $urandom_range(1, hdr - 1);
        frame_message(keep, cap);
    endfunction

    function automatic bit [30:0] pick_max();
        case ($urandom_range(0, 5))
            0:       return MAX_FRAG_RESET;
            1:       return 31'h7FFF_FFFF;
            2:       return $urandom_range(1, 8);
            3:       return $urandom_range(9, 300);
            4:       return 31'($urandom) | 31'd1;
            default: return MAX_FRAG_RESET;
        endcase
    endfunction

    task automatic send_byte(bit [7:0] b);
        int unsigned gap;
        gap = tx_eager ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        sb.note_byte(b);
    endtask

    task automatic send_some(int unsigned n);
        int unsigned cnt;
        cnt = (n > pending_q.size()) ? pending_q.size() : n;
        sending = 1'b1;
        repeat (cnt)
            send_byte(pending_q.pop_front());
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        sending = 1'b0;
    endtask

    task automatic wait_results();
        int unsigned cnt;
        cnt = 0;
        while (sb.waiting() != 0 && cnt < 20000)
        begin
            @(posedge clk);
            cnt++;
        end
    endtask

    // bytes that cause no result may still be in flight: allow the pipeline to empty
    task automatic settle();
        wait_results();
        repeat (6) @(posedge clk);
    endtask

    task automatic set_config(bit d, bit [30:0] m);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DIRECTION;
        cfg_data <= {30'b0, d};
        @(posedge clk);
        cfg_index <= CFG_MAX_FRAG_LEN;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(CFG_DIRECTION, {30'b0, d});
        sb.set_reg(CFG_MAX_FRAG_LEN, m);
        cur_dir = d;
        cur_max = m;
    endtask

    initial
    begin : result_sink
        int unsigned taken;
        int unsigned gap;
        bit          held;
        bit          eager;
        rpc_result_t got;
        taken = 0;
        held = 1'b0;
        eager = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && sending && taken >= 40)
            begin
                // long hold-off so the parser fills up and stalls its input
                held = 1'b1;
                gap = 400;
            end
            else
                gap = eager ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            got.ev      = event_t'(res_ch.event_res);
            got.xid     = res_ch.xid;
            got.rpcv    = res_ch.rpc_version;
            got.prog    = res_ch.program_number;
            got.vers    = res_ch.program_version;
            got.proc_no = res_ch.procedure_number;
            got.cred    = res_ch.cred_flavor;
            got.verf    = res_ch.verf_flavor;
            got.rstat   = res_ch.reply_status;
            got.astat   = res_ch.accept_status;
            got.hlen    = res_ch.header_length;
            got.last    = res_ch.last_of_run;
            sb.check_result(got);
            taken++;
            if (taken % 25 == 0)
                eager = ($urandom_range(0, 2) == 0);
        end
    end

    initial
    begin : stimulus
        int unsigned hdr;
        int unsigned n;
        int unsigned phase_no;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_DIRECTION;
        cfg_data <= '0;
        byte_ch.valid <= 1'b0;
        byte_ch.data_byte <= '0;
        sending = 1'b0;
        tx_eager = 1'b0;
        rand_bytes = 0;
        cur_dir = 1'b0;
        cur_max = MAX_FRAG_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calls: header and message done on one byte, rounded and huge opaques,
        // extreme words, zero and oversize markers, wrong type, short fragment
        set_config(1'b0, MAX_FRAG_RESET);
        hdr = build_message(1'b0, 32'd0, 32'd0, 32'd0, 0, 0);
        frame_whole();
        hdr = build_message(1'b0, 32'd0, 32'd5, 32'hFFFF_FFFF, 3, 1);
        frame_message(msg_q.size(), 7);
        hdr = build_message(1'b0, 32'd0, 32'd0, 32'd0, 2, 2);
        frame_whole();
        push_marker(32'h8000_0000);
        push_marker(32'h0010_0001);
        hdr = build_message(1'b1, 32'd1, 32'd0, 32'd0, 0, 0);
        frame_whole();
        hdr = build_message(1'b0, 32'd0, 32'd2, 32'd0, 4, 0);
        frame_message(hdr - 3, hdr);
        send_some(pending_q.size());
        settle();

        // replies at the widest fragment limit
        set_config(1'b1, 31'h7FFF_FFFF);
        hdr = build_message(1'b1, 32'd1, 32'd0, 32'd0, 0, 1);
        frame_whole();
        hdr = build_message(1'b1, 32'd1, 32'd3, 32'd0, 5, 0);
        frame_message(msg_q.size(), 2);
        hdr = build_message(1'b0, 32'd0, 32'd0, 32'd0, 0, 0);
        frame_whole();
        send_some(pending_q.size());
        settle();

        // tiny fragments and clamped opaques drive header_length into saturation
        set_config(1'b0, 31'd3);
        hdr = build_message(1'b0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 1, 0);
        frame_message(msg_q.size(), 3);
        send_some(pending_q.size());
        settle();

        // zero limit: every nonzero size is oversize
        set_config(1'b0, 31'd0);
        push_marker(32'h0000_0001);
        push_marker(32'h8000_0000);
        send_some(pending_q.size());
        settle();

        // switch to replies with the walker parked on the procedure word
        set_config(1'b0, MAX_FRAG_RESET);
        hdr = build_message(1'b0, 32'd0, 32'd0, 32'd0, 6, 0);
        frame_whole();
        send_some(24);
        settle();
        set_config(1'b1, MAX_FRAG_RESET);
        send_some(pending_q.size());
        settle();

        // switch to replies with the walker past the end of the reply fields
        set_config(1'b0, MAX_FRAG_RESET);
        hdr = build_message(1'b0, 32'd0, 32'd0, 32'd0, 4, 0);
        frame_whole();
        send_some(32);
        settle();
        set_config(1'b1, MAX_FRAG_RESET);
        send_some(pending_q.size());
        settle();

        phase_no = 0;
        while (rand_bytes < 750 || sb.produced < 60)
        begin
            set_config($urandom_range(0, 1), pick_max());
            tx_eager = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 10))
                add_random_message();
            n = pending_q.size();
            // sometimes stop mid-stream so the next setting applies mid-message
            if ($urandom_range(0, 2) == 0)
                n = $urandom_range(1, n);
            if (phase_no == 1)
            begin
                send_some(n / 2);
                wait_results();
                send_some(n - n / 2);
            end
            else
                send_some(n);
            rand_bytes += n;
            phase_no++;
            settle();
        end
        tx_eager = 1'b0;
        send_some(pending_q.size());
        settle();
        sb.flag_leftover();

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
